// ----- rtl/lphm_pkg.sv -----
// Shared types and constants of the linear probing hash map.
// Request and reply codes, field widths and stream packing offsets.
// No dependencies.
`default_nettype none

package lphm_pkg;

  // Field widths of a request and a reply
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 11;

  // Request stream packing: action, key, value from bit 0 up, padded to bytes
  localparam int IN_ACT_LSB  = 0;
  localparam int IN_KEY_LSB  = IN_ACT_LSB + ACTION_W;
  localparam int IN_VAL_LSB  = IN_KEY_LSB + KEY_W;
  localparam int IN_DATA_W   = ((IN_VAL_LSB + VALUE_W + 7) / 8) * 8;

  // Reply stream packing: status, found_value, entry_total from bit 0 up
  localparam int OUT_ST_LSB  = 0;
  localparam int OUT_VAL_LSB = OUT_ST_LSB + STATUS_W;
  localparam int OUT_TOT_LSB = OUT_VAL_LSB + VALUE_W;
  localparam int OUT_DATA_W  = ((OUT_TOT_LSB + TOTAL_W + 7) / 8) * 8;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [KEY_W-1:0]    key_t;

  // Request actions
  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_LOOKUP = 2'd1;
  localparam action_t ACT_DELETE = 2'd2;

  // Reply status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/linear_probe_hash_map_unit.sv -----
// Top level of the linear probing hash map: one slot memory, probe sequencer,
// reply register. Depends on lphm_pkg and lphm_home.
//
//   Channel  Dir  Handshake               Payload (low bit up)
//   in_      in   in_tvalid / in_tready   action[1:0] key[32:2] value[64:33]
//   out_     out  out_tvalid / out_tready status[1:0] found_value[33:2]
//                                          entry_total[44:34]
//
// One request at a time. Steps of a request: accept, the home slot (low key bits
// for a power-of-two CAPACITY, the reciprocal multiply otherwise), then the slots
// probed in turn through the single read port, then commit.
// After reset a clearing pass writes every slot with in_tready low. A stalled
// reply holds in the output register; the next request is still accepted and
// waits at commit until the register frees.
`default_nettype none

module linear_probe_hash_map_unit
  import lphm_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // action, key, value, pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // status, found_value, entry_total, pad
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int MEM_W = 2 + KEY_W + VALUE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  // Slot word: {used, deleted, key, value}
  logic [MEM_W-1:0] slot_mem [CAPACITY];
  logic [MEM_W-1:0] rdata_r;

  logic [2:0]            state_r,   state_nxt;
  action_t               act_r,     act_nxt;
  key_t                  key_r,     key_nxt;
  logic [VALUE_BITS-1:0] val_r,     val_nxt;
  logic [IDX_W-1:0]      cur_r,     cur_nxt;
  logic [IDX_W-1:0]      step_r,    step_nxt;
  logic                  hit_r,     hit_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [VALUE_BITS-1:0] hit_val_r, hit_val_nxt;
  logic                  free_r,    free_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]      cnt_r,     cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_value_r,  out_value_nxt;
  logic [TOTAL_W-1:0]    out_total_r,  out_total_nxt;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [MEM_W-1:0]      wr_data;

  logic                  mod_start;
  logic                  mod_done;
  logic [IDX_W-1:0]      mod_home;

  logic                  in_fire;
  logic                  slot_used;
  logic                  slot_del;
  key_t                  slot_key;
  logic [VALUE_BITS-1:0] slot_val;
  logic [IDX_W-1:0]      next_idx;
  logic                  reply_free;

  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign reply_free = !out_valid_r || out_tready;

  assign slot_used = rdata_r[MEM_W-1];
  assign slot_del  = rdata_r[MEM_W-2];
  assign slot_key  = rdata_r[VALUE_BITS +: KEY_W];
  assign slot_val  = rdata_r[VALUE_BITS-1:0];
  assign next_idx  = (cur_r == LAST_IDX) ? '0 : cur_r + IDX_W'(1);

  // Home slot of the accepted key
  lphm_home #(
    .CAPACITY (CAPACITY)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_tdata[IN_KEY_LSB +: KEY_W]),
    .done  (mod_done),
    .home  (mod_home)
  );

  // Slot memory: one write port, one registered read port. Writes happen only
  // in the clear and commit states, reads only in hash and probe, so a read
  // never meets a write to the same slot in one cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= slot_mem[rd_addr];
    end
  end

  // Sequencer: clear, accept, hash, walk the chain, commit
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    step_nxt       = step_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_val_nxt    = hit_val_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_total_nxt  = out_total_r;
    rd_en          = 1'b0;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = '0;
    mod_start      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // Mark every slot never-used
        wr_en = 1'b1;
        if (cur_r == LAST_IDX) begin
          cur_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cur_nxt = next_idx;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          act_nxt  = in_tdata[IN_ACT_LSB +: ACTION_W];
          key_nxt  = in_tdata[IN_KEY_LSB +: KEY_W];
          val_nxt  = VALUE_BITS'(in_tdata[IN_VAL_LSB +: VALUE_W]);
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          if (in_tdata[IN_ACT_LSB +: ACTION_W] == ACT_INSERT ||
              in_tdata[IN_ACT_LSB +: ACTION_W] == ACT_LOOKUP ||
              in_tdata[IN_ACT_LSB +: ACTION_W] == ACT_DELETE) begin
            mod_start = 1'b1;
            state_nxt = S_HASH;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end

      S_HASH: begin
        // Read the home slot
        if (mod_done) begin
          rd_en     = 1'b1;
          rd_addr   = mod_home;
          cur_nxt   = mod_home;
          step_nxt  = '0;
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        if (!slot_used) begin
          // Never-used slot ends the chain
          if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cur_r;
          end
          state_nxt = S_COMMIT;
        end else if (!slot_del && slot_key == key_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cur_r;
          hit_val_nxt = slot_val;
          state_nxt   = S_COMMIT;
        end else begin
          // Remember the first tombstone, then advance or give up
          if (slot_del && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cur_r;
          end
          if (step_r == LAST_IDX) begin
            state_nxt = S_COMMIT;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = next_idx;
            cur_nxt  = next_idx;
            step_nxt = step_r + IDX_W'(1);
          end
        end
      end

      S_COMMIT: begin
        // Write back and load the reply once the output register is free
        if (reply_free) begin
          out_status_nxt = ST_NOT_FOUND;
          out_value_nxt  = '0;
          case (act_r)
            ACT_INSERT: begin
              if (hit_r) begin
                wr_en          = 1'b1;
                wr_addr        = hit_idx_r;
                wr_data        = {1'b1, 1'b0, key_r, val_r};
                out_status_nxt = ST_OK;
              end else if (free_r) begin
                wr_en          = 1'b1;
                wr_addr        = free_idx_r;
                wr_data        = {1'b1, 1'b0, key_r, val_r};
                cnt_nxt        = cnt_r + CNT_W'(1);
                out_status_nxt = ST_OK;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            ACT_LOOKUP: begin
              if (hit_r) begin
                out_value_nxt  = VALUE_W'(hit_val_r);
                out_status_nxt = ST_OK;
              end
            end
            ACT_DELETE: begin
              if (hit_r) begin
                wr_en          = 1'b1;
                wr_addr        = hit_idx_r;
                wr_data        = {1'b1, 1'b1, key_r, hit_val_r};
                if (cnt_r != '0) begin
                  cnt_nxt = cnt_r - CNT_W'(1);
                end
                out_status_nxt = ST_OK;
              end
            end
            default: begin
              out_status_nxt = ST_NOT_FOUND;
            end
          endcase
          out_total_nxt = TOTAL_W'(cnt_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    step_r       <= step_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_val_r    <= hit_val_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_total_r  <= out_total_nxt;
  end

  // Drive the reply stream
  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_ST_LSB  +: STATUS_W] = out_status_r;
    out_tdata[OUT_VAL_LSB +: VALUE_W]  = out_value_r;
    out_tdata[OUT_TOT_LSB +: TOTAL_W]  = out_total_r;
  end

endmodule

`default_nettype wire

// ----- rtl/lphm_home.sv -----
// Home slot unit: key modulo CAPACITY.
// Power-of-two capacity takes the low key bits; any other capacity runs a
// reciprocal multiply with one correction step.
// Uses lphm_pkg.
`default_nettype none

module lphm_home
  import lphm_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire key_t                        key,
  output logic                             done,
  output logic [$clog2(CAPACITY)-1:0]      home
);

  localparam int  IDX_W   = $clog2(CAPACITY);
  localparam bit  IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

  generate
    if (IS_POW2) begin : g_pow2
      logic             done_r;
      logic [IDX_W-1:0] home_r;

      // Take the low key bits
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          home_r <= key[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end else begin : g_div
      // Reciprocal scaled by 2^SHIFT; the quotient estimate is low by at most one
      localparam int             SHIFT = KEY_W + IDX_W;
      localparam int             Q_W   = 32 - IDX_W;
      localparam int             PQ_W  = Q_W + IDX_W + 1;
      localparam logic [31:0]    RECIP = 32'((64'd1 << SHIFT) / 64'(CAPACITY));
      localparam logic [IDX_W:0] CAP   = (IDX_W + 1)'(CAPACITY);

      logic              v1_r;
      logic              v2_r;
      logic              done_r;
      key_t              key_r;
      logic [KEY_W+31:0] prod_r;
      key_t              qc_r;
      logic [IDX_W-1:0]  home_r;
      logic [Q_W-1:0]    quo;
      logic [PQ_W-1:0]   quo_cap;
      key_t              diff;
      logic [IDX_W:0]    rem_est;

      assign quo     = prod_r[KEY_W+31 : SHIFT];
      assign quo_cap = PQ_W'(quo) * PQ_W'(CAP);
      assign diff    = key_r - qc_r;
      assign rem_est = diff[IDX_W:0];

      // Multiply by the reciprocal, form quotient times capacity, correct once
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r   <= 1'b0;
          v2_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          v1_r   <= start;
          v2_r   <= v1_r;
          done_r <= v2_r;
        end
        if (start) begin
          key_r  <= key;
          prod_r <= (KEY_W + 32)'(key) * (KEY_W + 32)'(RECIP);
        end
        qc_r <= quo_cap[KEY_W-1:0];
        if (v2_r) begin
          home_r <= (rem_est >= CAP) ? IDX_W'(rem_est - CAP) : IDX_W'(rem_est);
        end
      end

      assign done = done_r;
      assign home = home_r;
    end
  endgenerate

endmodule

`default_nettype wire

// ----- rtl/lphm_chk.sv -----
// Port-level checker of the linear probing hash map, bound to the top level.
// Depends on lphm_pkg.
`default_nettype none

module lphm_chk
  import lphm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  status_t            st;
  logic [VALUE_W-1:0] found;

  assign st    = out_tdata[OUT_ST_LSB +: STATUS_W];
  assign found = out_tdata[OUT_VAL_LSB +: VALUE_W];

  // Reset leaves no reply and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("reply or ready right after reset");

  // One request at a time: ready drops after each accepted request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == ST_OK || st == ST_NOT_FOUND || st == ST_FULL))
    else $error("undefined status code");

  // A value is only reported with a successful request
  a_value_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |-> found == '0)
    else $error("nonzero value on a failed request");

  // A stalled reply holds
  a_reply_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled reply changed");

endmodule

bind linear_probe_hash_map_unit lphm_chk u_lphm_chk (.*);

`default_nettype wire

// ----- tb/tb_linear_probe_hash_map_unit.sv -----
// Self-checking testbench for linear_probe_hash_map_unit: a scoreboard class
// predicts each reply from its own copy of the slot table. Depends on lphm_pkg.
`timescale 1ns / 1ps

module tb_linear_probe_hash_map_unit;
  import lphm_pkg::*;

  localparam int SLOTS = 1024;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 7;
  // Longest probe walks every slot; allow accept, commit and some margin
  localparam int PROBE_LATENCY = SLOTS + 64;
  localparam int LONG_HOLD = 400;

  // Spare action code with no operation behind it
  localparam action_t ACT_UNUSED = 2'd3;

  typedef struct {
    status_t             status;
    logic [VALUE_W-1:0]  found;
    logic [TOTAL_W-1:0]  total;
  } reply_t;

  // Predicts replies from a private slot table and checks the replies seen
  class reply_checker;
    bit                 slot_used[SLOTS];
    bit                 slot_tomb[SLOTS];
    key_t               key_store[SLOTS];
    logic [VALUE_W-1:0] value_store[SLOTS];
    int                 live_count;
    reply_t             pending_replies[$];
    int                 error_count;
    int                 replies_checked;
    int                 status_seen[3];
    int                 peak_live;

    function new();
      live_count = 0;
      error_count = 0;
      replies_checked = 0;
      peak_live = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_tomb[i] = 1'b0;
      end
    endfunction

    task report_mismatch(string what);
      error_count++;
      if (error_count <= 100) $display("[%0t] mismatch %0d: %s", $time, error_count, what);
    endtask

    // Walk the chain of k: live slot holding it, and first reusable slot
    function void probe(key_t k, output int hit, output int free_slot);
      int idx;
      idx = int'(k % SLOTS);
      hit = SLOTS;
      free_slot = SLOTS;
      for (int n = 0; n < SLOTS; n++) begin
        if (!slot_used[idx]) begin
          if (free_slot == SLOTS) free_slot = idx;
          return;
        end
        if (slot_tomb[idx]) begin
          if (free_slot == SLOTS) free_slot = idx;
        end else if (key_store[idx] == k) begin
          hit = idx;
          return;
        end
        idx = (idx + 1) % SLOTS;
      end
    endfunction

    // Apply an accepted request to the table and queue its reply
    function void note_request(action_t act, key_t k, logic [VALUE_W-1:0] v);
      reply_t r;
      int hit;
      int free_slot;
      r.status = ST_NOT_FOUND;
      r.found = '0;
      if (act != ACT_UNUSED) begin
        probe(k, hit, free_slot);
        case (act)
          ACT_INSERT: begin
            if (hit < SLOTS) begin
              value_store[hit] = v;
              r.status = ST_OK;
            end else if (free_slot < SLOTS) begin
              slot_used[free_slot] = 1'b1;
              slot_tomb[free_slot] = 1'b0;
              key_store[free_slot] = k;
              value_store[free_slot] = v;
              live_count++;
              r.status = ST_OK;
            end else begin
              r.status = ST_FULL;
            end
          end
          ACT_LOOKUP: begin
            if (hit < SLOTS) begin
              r.found = value_store[hit];
              r.status = ST_OK;
            end
          end
          default: begin
            if (hit < SLOTS) begin
              slot_tomb[hit] = 1'b1;
              if (live_count > 0) live_count--;
              r.status = ST_OK;
            end
          end
        endcase
      end
      if (live_count > peak_live) peak_live = live_count;
      r.total = live_count[TOTAL_W-1:0];
      pending_replies.push_back(r);
    endfunction

    // Compare one accepted reply with the oldest prediction
    task check_reply(logic [OUT_DATA_W-1:0] word);
      reply_t exp_r;
      status_t got_status;
      logic [VALUE_W-1:0] got_found;
      logic [TOTAL_W-1:0] got_total;
      got_status = word[OUT_ST_LSB +: STATUS_W];
      got_found = word[OUT_VAL_LSB +: VALUE_W];
      got_total = word[OUT_TOT_LSB +: TOTAL_W];
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply with no request outstanding, data %h", word));
      end else begin
        exp_r = pending_replies.pop_front();
        replies_checked++;
        if (exp_r.status <= ST_FULL) status_seen[exp_r.status]++;
        if (got_status !== exp_r.status)
          report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    replies_checked, got_status, exp_r.status));
        if (got_found !== exp_r.found)
          report_mismatch($sformatf("reply %0d found_value %h, want %h",
                                    replies_checked, got_found, exp_r.found));
        if (got_total !== exp_r.total)
          report_mismatch($sformatf("reply %0d entry_total %0d, want %0d",
                                    replies_checked, got_total, exp_r.total));
      end
    endtask

    task flush_leftovers();
      while (pending_replies.size() > 0) begin
        void'(pending_replies.pop_front());
        report_mismatch("predicted reply never arrived");
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // action, key, value, pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // status, found_value, entry_total, pad

  reply_checker sb = new();
  int  burst_left = 0;
  bit  hold_off = 1'b0;

  linear_probe_hash_map_unit #(
    .CAPACITY   (SLOTS),
    .VALUE_BITS (VALUE_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #(80_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Check every reply taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata);
  end

  // Long receiver hold once replies flow, counted in cycles
  initial begin
    wait (rst_n);
    while (sb.replies_checked < 40) @(negedge clk);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Receiver: segments of steady, random and sparse ready
  initial begin
    int seg;
    int mode;
    int phase;
    bit rdy;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(5, 60);
      phase = 0;
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (phase % 3 == 0);
          default: rdy = ($urandom_range(0, 7) == 0);
        endcase
        out_tready <= rdy && !hold_off;
        phase++;
      end
    end
  end

  // Offer one request and hold it until taken; idle between bursts
  task automatic send_request(action_t act, key_t k, logic [VALUE_W-1:0] v);
    int gap;
    logic [IN_DATA_W-1:0] word;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    word = '0;
    word[IN_ACT_LSB +: ACTION_W] = act;
    word[IN_KEY_LSB +: KEY_W] = k;
    word[IN_VAL_LSB +: VALUE_W] = v;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(act, k, v);
  endtask

  // Keys crowded around the table wrap point, with some spread anywhere
  function automatic key_t crowded_key();
    int home;
    if ($urandom_range(0, 4) == 0) return key_t'($urandom());
    home = (SLOTS - 8 + $urandom_range(0, 47)) % SLOTS;
    return key_t'(home + SLOTS * $urandom_range(0, 3));
  endfunction

  function automatic action_t random_action();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return ACT_INSERT;
    if (pick < 70) return ACT_LOOKUP;
    if (pick < 92) return ACT_DELETE;
    return ACT_UNUSED;
  endfunction

  initial begin
    int cycles;
    int slot;
    int pick;
    key_t k;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, update, wrap, tombstones, spare code
    send_request(ACT_LOOKUP, key_t'(0), 32'h0);
    send_request(ACT_DELETE, key_t'(0), 32'hFFFF_FFFF);
    send_request(ACT_INSERT, key_t'(0), 32'h0000_0000);
    send_request(ACT_INSERT, key_t'(31'h7FFF_FFFF), 32'hFFFF_FFFF);
    send_request(ACT_INSERT, key_t'(2047), 32'h1234_5678);
    send_request(ACT_LOOKUP, key_t'(2047), 32'h0);
    send_request(ACT_INSERT, key_t'(0), 32'hA5A5_A5A5);
    send_request(ACT_LOOKUP, key_t'(0), 32'h0);
    send_request(ACT_DELETE, key_t'(31'h7FFF_FFFF), 32'h0);
    send_request(ACT_LOOKUP, key_t'(2047), 32'h0);
    send_request(ACT_INSERT, key_t'(3071), 32'h5A5A_5A5A);
    send_request(ACT_LOOKUP, key_t'(3071), 32'h0);
    send_request(ACT_DELETE, key_t'(31'h7FFF_FFFF), 32'h0);
    send_request(ACT_UNUSED, key_t'(0), 32'h0);
    send_request(ACT_UNUSED, key_t'(31'h7FFF_FFFF), 32'hFFFF_FFFF);
    send_request(ACT_LOOKUP, key_t'(31'h7FFF_FFFF), 32'h0);
    send_request(ACT_DELETE, key_t'(2047), 32'h0);
    send_request(ACT_INSERT, key_t'(2047), 32'hDEAD_BEEF);
    send_request(ACT_LOOKUP, key_t'(2047), 32'h0);
    send_request(ACT_LOOKUP, key_t'(1024), 32'h0);

    // Random mix on a partly filled table with long colliding chains
    repeat (900) send_request(random_action(), crowded_key(), $urandom());

    // Fill every unused slot by homing a fresh key on it
    for (int s = 0; s < SLOTS; s++) begin
      if (!sb.slot_used[s]) begin
        k = key_t'({21'($urandom()), 10'(s)});
        send_request(ACT_INSERT, k, $urandom());
      end
    end

    // Full table: hits, misses, inserts into tombstones or rejected as full
    repeat (100) begin
      slot = $urandom_range(0, SLOTS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 35) send_request(ACT_LOOKUP, sb.key_store[slot], $urandom());
      else if (pick < 55) send_request(ACT_DELETE, sb.key_store[slot], $urandom());
      else if (pick < 70) send_request(ACT_INSERT, sb.key_store[slot], $urandom());
      else if (pick < 85) send_request(ACT_INSERT, key_t'($urandom()), $urandom());
      else if (pick < 95) send_request(ACT_LOOKUP, key_t'($urandom()), $urandom());
      else send_request(ACT_UNUSED, key_t'($urandom()), $urandom());
    end

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain outstanding replies, then watch for strays
    cycles = 0;
    while (sb.pending_replies.size() > 0 && cycles < 200 * PROBE_LATENCY) begin
      @(posedge clk);
      cycles++;
    end
    repeat (PROBE_LATENCY) @(posedge clk);
    sb.flush_leftovers();

    $display("Checked %0d replies: %0d done or found, %0d not found, %0d table full.",
             sb.replies_checked, sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_FULL]);
    $display("Peak live entries %0d of %0d slots; %0d mismatches.",
             sb.peak_live, SLOTS, sb.error_count);
    if (sb.error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
